// File: rtl/core/rsrg_pkg.sv
// shared constants and types for the replacement selection run generator
`timescale 1ns / 1ps

package rsrg_pkg;

	localparam int BUF_SIZE = 4;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(BUF_SIZE + 1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic shift;   // each cell takes its right neighbor's key; the tail cell keeps its own
		logic insert;  // sorted insertion of the broadcast key
	} cell_ctl_t;

endpackage

// File: rtl/core/rsrg_cell.sv
// one cell of the sorted key chain
`timescale 1ns / 1ps

module rsrg_cell
	import rsrg_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occ,        // cell holds a live key
	input  key_t      ins_key,    // key being inserted
	input  logic      left_gt,    // left neighbor moves right on insert
	input  key_t      left_key,
	input  key_t      right_key,
	output logic      gt,         // own key is above ins_key, or cell is empty
	output key_t      key
);

	key_t key_q;

	assign gt  = !occ || (key_q > ins_key);
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= right_key;
		end else if (ctl.insert && gt) begin
			key_q <= left_gt ? left_key : ins_key;
		end
	end

endmodule

// File: rtl/core/replacement_selection_run_generator_unit.sv
// top level: replacement selection run generator built on a sorted cell chain
//
// channel   handshake                    payload
// -------   --------------------------   -------------------------
// item      item_valid / item_ready      value (s32), last
// result    result_valid / result_ready  key_out (s32), run_end
//
// keys sit in a chain of BUF_SIZE cells kept in ascending order, cell 0 the minimum
// while the buffer fills an item is accepted, then inserted; when full it is accepted, the minimum
// is popped, then the item is inserted; flushed keys leave the chain one by one
// the sequencer handles one item at a time: item_ready is high only when idle
// the result register frees on the cycle it is taken, so a stalled result only
// holds the chain while a new key must go out
// reset clears the fill count, the sequencer, the pending-insert flag and the result valid; cell keys are not reset
`timescale 1ns / 1ps

module replacement_selection_run_generator_unit
	import rsrg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] value,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] key_out,
	output logic        run_end
);

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_POP    = 3'd1;  // emit the minimum ahead of the new key
	localparam logic [2:0] ST_INSERT = 3'd2;  // sorted insertion of the held key
	localparam logic [2:0] ST_FLUSH  = 3'd3;  // drain the chain, closing the run

	logic [2:0] state_q;
	logic [2:0] state_d;
	cnt_t       cnt_q;
	key_t       v_q;         // held input key
	logic       last_q;      // held last flag
	logic       ins_pend_q;  // key below minimum: insert it once the flush is done

	logic       out_vld_q;
	key_t       key_out_q;
	logic       run_end_q;

	logic       out_free;
	logic       emit;
	logic       emit_end;
	cell_ctl_t  ctl;

	key_t       cell_key [BUF_SIZE];
	logic       cell_gt  [BUF_SIZE];

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_vld_q;
	assign key_out      = key_out_q;
	assign run_end      = run_end_q;

	// result register may be loaded when empty or being taken this cycle
	assign out_free = !out_vld_q || result_ready;
	assign emit     = ((state_q == ST_POP) || (state_q == ST_FLUSH)) && out_free;
	assign emit_end = (state_q == ST_FLUSH) && (cnt_q == cnt_t'(1));

	always_comb begin
		ctl.shift  = emit;
		ctl.insert = (state_q == ST_INSERT);
	end

	// chain of cells, each cell wired to its neighbors
	for (genvar i = 0; i < BUF_SIZE; i++) begin : g_cell
		logic left_gt;
		key_t left_key;
		key_t right_key;

		if (i == 0) begin : g_head
			assign left_gt  = 1'b0;
			assign left_key = v_q;
		end else begin : g_mid
			assign left_gt  = cell_gt[i-1];
			assign left_key = cell_key[i-1];
		end

		if (i == BUF_SIZE - 1) begin : g_tail
			assign right_key = cell_key[i];
		end else begin : g_body
			assign right_key = cell_key[i+1];
		end

		rsrg_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (cnt_t'(i) < cnt_q),
			.ins_key   (v_q),
			.left_gt   (left_gt),
			.left_key  (left_key),
			.right_key (right_key),
			.gt        (cell_gt[i]),
			.key       (cell_key[i])
		);
	end

	// next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = (cnt_q < cnt_t'(BUF_SIZE)) ? ST_INSERT : ST_POP;
				end
			end
			ST_POP: begin
				if (out_free) begin
					state_d = (v_q >= cell_key[0]) ? ST_INSERT : ST_FLUSH;
				end
			end
			ST_INSERT: begin
				state_d = last_q ? ST_FLUSH : ST_IDLE;
			end
			ST_FLUSH: begin
				if (out_free && emit_end) begin
					state_d = ins_pend_q ? ST_INSERT : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ins_pend_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// fill count tracks the live cells
			if (state_q == ST_INSERT) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end else if (emit) begin
				cnt_q <= cnt_q - cnt_t'(1);
			end

			// new key below the minimum ends the run before it is stored
			if ((state_q == ST_POP) && out_free && (v_q < cell_key[0])) begin
				ins_pend_q <= 1'b1;
			end else if (state_q == ST_INSERT) begin
				ins_pend_q <= 1'b0;
			end

			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			v_q    <= value;
			last_q <= last;
		end
		if (emit) begin
			key_out_q <= cell_key[0];
			run_end_q <= emit_end;
		end
	end

endmodule

// File: tb/tb_replacement_selection_run_generator_unit.sv
// testbench for the replacement selection run generator: directed, random streams vs a run predictor
`timescale 1ns / 1ps

module tb_replacement_selection_run_generator_unit;
	import rsrg_pkg::*;

	// cycles with no transaction on either channel before the run is declared hung
	localparam int STALL_LIMIT = 5000;
	// quiet cycles after the last expected key, well above one full flush
	localparam int TAIL_CYCLES = 30;
	localparam int MAX_REPORTS = 10;

	localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);
	localparam key_t KEY_MIN = key_t'(32'h8000_0000);

	typedef struct {
		key_t key;
		logic last;
	} stream_item_t;

	typedef struct {
		key_t key;
		logic run_end;
	} run_key_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [31:0] value = '0;
	logic        last = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] key_out;
	logic        run_end;

	replacement_selection_run_generator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.key_out      (key_out),
		.run_end      (run_end)
	);

	// stimulus waiting for the driver, and keys the block still owes us
	stream_item_t pending_items[$];
	run_key_t     expected_keys[$];
	// predictor copy of the buffer: the keys currently held by the block
	key_t         held_keys[$];

	int   items_queued = 0;
	int   items_accepted = 0;
	int   mismatches = 0;
	int   stall_cycles = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic item_taken = 1'b0;
	// random walk used to build long ascending stretches, so runs grow past the buffer size
	key_t drift = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	// emit every held key in ascending order, run_end on the largest, and empty the buffer
	task automatic flush_held();
		key_t     srt[$];
		key_t     t;
		int       j;
		run_key_t r;
		srt = held_keys;
		for (int i = 1; i < srt.size(); i++) begin
			t = srt[i];
			j = i;
			while (j > 0 && srt[j-1] > t) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = t;
		end
		foreach (srt[i]) begin
			r.key = srt[i];
			r.run_end = (i == srt.size() - 1);
			expected_keys.push_back(r);
		end
		held_keys.delete();
	endtask

	// work out the keys one accepted input transaction releases
	task automatic predict_runs(key_t k, logic lst);
		int       lo;
		run_key_t r;
		if (held_keys.size() < BUF_SIZE) begin
			// still filling: store only
			held_keys.push_back(k);
		end else begin
			lo = 0;
			for (int i = 1; i < BUF_SIZE; i++) begin
				if (held_keys[i] < held_keys[lo])
					lo = i;
			end
			r.key = held_keys[lo];
			r.run_end = 1'b0;
			expected_keys.push_back(r);
			if (k >= held_keys[lo]) begin
				// new key can still join the current run
				held_keys[lo] = k;
			end else begin
				// new key is too small: close the run with the rest, start a fresh one
				held_keys.delete(lo);
				flush_held();
				held_keys.push_back(k);
			end
		end
		if (lst)
			flush_held();
	endtask

	task automatic queue_item(key_t k, logic lst);
		stream_item_t it;
		it.key = k;
		it.last = lst;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// half the time a rising walk with occasional drops, plus full-range, tiny-range and extreme keys
	task automatic pick_key(output key_t k);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			if (sel < 4)
				drift = $urandom;
			drift = drift + key_t'(int'($urandom_range(0, 40)) - 8);
			k = drift;
		end else if (sel < 70) begin
			k = $urandom;
		end else if (sel < 85) begin
			k = key_t'(int'($urandom_range(0, 7)) - 4);
		end else begin
			case ($urandom_range(0, 3))
				0: k = KEY_MIN;
				1: k = KEY_MAX;
				2: k = '0;
				default: k = '1;
			endcase
		end
	endtask

	// whole streams, each closed by last; a few short ones end while the buffer still fills
	task automatic queue_random_streams(int n_items);
		int   made;
		int   len;
		int   sel;
		key_t k;
		made = 0;
		while (made < n_items) begin
			sel = $urandom_range(0, 9);
			if (sel < 2)
				len = $urandom_range(1, BUF_SIZE);
			else if (sel < 9)
				len = $urandom_range(BUF_SIZE + 1, 14);
			else
				len = $urandom_range(15, 30);
			for (int i = 0; i < len; i++) begin
				pick_key(k);
				queue_item(k, i == len - 1);
			end
			made += len;
		end
	endtask

	task automatic wait_drained();
		while (!(items_accepted == items_queued && expected_keys.size() == 0))
			@(posedge clk);
	endtask

	task automatic note_mismatch(logic have_exp, run_key_t e);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			if (have_exp)
				$display("mismatch: expected key %0d run_end %0b, got key %0d run_end %0b",
					e.key, e.run_end, $signed(key_out), run_end);
			else
				$display("unexpected result transaction: key %0d run_end %0b",
					$signed(key_out), run_end);
		end
	endtask

	// driver: inputs move only on the falling edge, and a held item stays put until taken
	always @(negedge clk) begin : driver
		stream_item_t nxt;
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					value <= nxt.key;
					last <= nxt.last;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: check each result transaction, then feed the accepted item to the predictor
	always @(posedge clk) begin : monitor
		run_key_t e;
		if (arst_n) begin
			item_taken <= item_valid && item_ready;
			if (result_valid && result_ready) begin
				if (expected_keys.size() == 0) begin
					e.key = '0;
					e.run_end = 1'b0;
					note_mismatch(1'b0, e);
				end else begin
					e = expected_keys.pop_front();
					if (key_out !== e.key || run_end !== e.run_end)
						note_mismatch(1'b1, e);
				end
			end
			if (item_valid && item_ready) begin
				items_accepted++;
				predict_runs(key_t'(value), last);
			end
		end
	end

	// watchdog: any transaction on either channel restarts the count
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_replacement_selection_run_generator_unit NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// phase one: slow receiver
		send_idle_pct = 21;
		recv_idle_pct = 73;

		// single key stream, ends while filling
		queue_item(7, 1'b1);
		// partial buffer with both extremes
		queue_item(KEY_MAX, 1'b0);
		queue_item(KEY_MIN, 1'b0);
		queue_item('0, 1'b1);
		// fill, replace the minimum twice, then drop below it to split the run
		queue_item('1, 1'b0);
		queue_item(5, 1'b0);
		queue_item(5, 1'b0);
		queue_item(2, 1'b0);
		queue_item(5, 1'b0);
		queue_item(3, 1'b0);
		queue_item(1, 1'b0);
		// all keys equal, last not below the minimum
		queue_item(1, 1'b0);
		queue_item(1, 1'b0);
		queue_item(1, 1'b0);
		queue_item(1, 1'b1);
		// last with a full buffer and a key below the minimum: two runs close
		queue_item(10, 1'b0);
		queue_item(20, 1'b0);
		queue_item(30, 1'b0);
		queue_item(40, 1'b0);
		queue_item(5, 1'b1);
		// repeated extremes, last not below the minimum
		queue_item(KEY_MAX, 1'b0);
		queue_item(KEY_MAX, 1'b0);
		queue_item(KEY_MIN, 1'b0);
		queue_item(KEY_MIN, 1'b0);
		queue_item(KEY_MAX, 1'b1);

		queue_random_streams(28);
		wait_drained();

		// phase two: slow sender
		send_idle_pct = 73;
		recv_idle_pct = 21;
		queue_random_streams(28);
		wait_drained();

		// phase three: both sides at full rate
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_streams(28);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_keys.size() == 0)
			$display("tb_replacement_selection_run_generator_unit OK");
		else
			$display("tb_replacement_selection_run_generator_unit NOT OK");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/rsrg_pkg.sv
rtl/core/rsrg_cell.sv
rtl/core/replacement_selection_run_generator_unit.sv
tb/tb_replacement_selection_run_generator_unit.sv
